[sv/nose_hoover_verlet_step_assert.svh]
// assertion macros shared by the block's modules
`ifndef NOSE_HOOVER_VERLET_STEP_ASSERT_SVH
`define NOSE_HOOVER_VERLET_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define NHV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define NHV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NHV_ASSERT(lbl, prop, msg)
`define NHV_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/nhv_pkg.sv]
package nhv_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_DIMS  = 3;

    // configuration register indexes
    localparam logic [2:0] CFG_TIME_STEP   = 3'd0;
    localparam logic [2:0] CFG_THERMO_MASS = 3'd1;
    localparam logic [2:0] CFG_TARGET_TEMP = 3'd2;
    localparam logic [2:0] CFG_BOLTZMANN   = 3'd3;
    localparam logic [2:0] CFG_DIMENSIONS  = 3'd4;
    localparam logic [2:0] CFG_WAIT_STEPS  = 3'd5;

    localparam logic [47:0]        KSUM_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [63:0] SAT_WIDE  = 64'sh3FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] I32_MAX_W = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN_W = -64'sd2147483648;
    localparam logic [31:0]        I32_MAX   = 32'h7FFF_FFFF;

    // datapath operations
    typedef enum logic [3:0] {
        OP_KSQ,
        OP_KDIV,
        OP_FIM,
        OP_FZV,
        OP_KICK,
        OP_DRIFT,
        OP_ITEM_END,
        OP_TK,
        OP_TW,
        OP_NUM,
        OP_ZDIV,
        OP_DEN,
        OP_LDIV,
        OP_CLOSE,
        OP_EMIT
    } t_op;

    typedef struct packed {
        logic       start;
        t_op        op;
        logic [1:0] comp;
    } t_dp_cmd;

    typedef struct packed {
        logic       done;
        logic       cmd;
        logic       last;
        logic [1:0] dims;
        logic       q_valid;
        logic       learn_now;
    } t_dp_sts;

    typedef struct packed {
        logic            command;
        logic [2:0][31:0] pos;
        logic [2:0][31:0] vel;
        logic [2:0][31:0] frc;
        logic [31:0]     inverse_mass;
        logic            last_particle;
    } t_item;

    typedef struct packed {
        logic [2:0][31:0] nvel;
        logic [2:0][31:0] npos;
        logic [31:0]     friction;
        logic [31:0]     temperature;
        logic            pass_done;
    } t_result;

    function automatic logic signed [63:0] sx64(input logic [31:0] x);
        return {{32{x[31]}}, x};
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        logic [31:0] r;
        if (x > I32_MAX_W) begin
            r = I32_MAX_W[31:0];
        end else if (x < I32_MIN_W) begin
            r = I32_MIN_W[31:0];
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat_wide(input logic signed [63:0] x);
        logic signed [63:0] r;
        if (x > SAT_WIDE) begin
            r = SAT_WIDE;
        end else if (x < -SAT_WIDE) begin
            r = -SAT_WIDE;
        end else begin
            r = x;
        end
        return r;
    endfunction

endpackage

[sv/nhv_if.sv]
// particle word into the block
interface nhv_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] pos_a;
    logic signed [31:0] pos_b;
    logic signed [31:0] pos_c;
    logic signed [31:0] vel_a;
    logic signed [31:0] vel_b;
    logic signed [31:0] vel_c;
    logic signed [31:0] force_a;
    logic signed [31:0] force_b;
    logic signed [31:0] force_c;
    logic [31:0]        inverse_mass;
    logic               last_particle;

    modport source (
        output valid, command, pos_a, pos_b, pos_c, vel_a, vel_b, vel_c,
               force_a, force_b, force_c, inverse_mass, last_particle,
        input  ready
    );
    modport sink (
        input  valid, command, pos_a, pos_b, pos_c, vel_a, vel_b, vel_c,
               force_a, force_b, force_c, inverse_mass, last_particle,
        output ready
    );
endinterface

// result word out of the block
interface nhv_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_vel_a;
    logic signed [31:0] new_vel_b;
    logic signed [31:0] new_vel_c;
    logic signed [31:0] new_pos_a;
    logic signed [31:0] new_pos_b;
    logic signed [31:0] new_pos_c;
    logic signed [31:0] friction_out;
    logic signed [31:0] temperature_out;
    logic               pass_done;

    modport source (
        output valid, new_vel_a, new_vel_b, new_vel_c, new_pos_a, new_pos_b,
               new_pos_c, friction_out, temperature_out, pass_done,
        input  ready
    );
    modport sink (
        input  valid, new_vel_a, new_vel_b, new_vel_c, new_pos_a, new_pos_b,
               new_pos_c, friction_out, temperature_out, pass_done,
        output ready
    );
endinterface

[sv/nhv_div.sv]
`include "nose_hoover_verlet_step_assert.svh"

module nhv_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);
    logic        r_busy;
    logic        r_fin;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_div;
    logic [64:0] rem_sh;
    logic        ge;

    // one restoring step per cycle
    assign rem_sh = {r_rem, r_quo[63]};
    assign ge     = rem_sh >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? 64'(rem_sh - {1'b0, r_div}) : rem_sh[63:0];
                r_quo <= {r_quo[62:0], ge};
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    assign o_done     = r_fin;
    assign o_quotient = r_quo;

    `NHV_ASSERT(a_div_nonzero, i_start |-> i_divisor != 64'd0, "divide by zero started")
endmodule

[sv/nhv_ctrl.sv]
`include "nose_hoover_verlet_step_assert.svh"

module nhv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  nhv_pkg::t_dp_sts i_sts,
    output nhv_pkg::t_dp_cmd o_cmd,
    output logic            o_in_ready
);
    import nhv_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT} t_state;

    t_state     r_state;
    t_op        r_op;
    logic [1:0] r_comp;
    t_op        n_op;
    logic [1:0] n_comp;
    t_op        comp_op;
    t_op        after_z;
    logic       more_comp;

    // operation sequence of one particle and of the pass end
    always_comb begin
        more_comp = ({1'b0, r_comp} + 3'd1) < {1'b0, i_sts.dims};
        comp_op   = more_comp ? OP_KSQ : OP_ITEM_END;
        after_z   = i_sts.learn_now ? OP_DEN : OP_CLOSE;
        n_comp    = r_comp;
        case (r_op)
            OP_KSQ:      n_op = OP_KDIV;
            OP_KDIV:     n_op = OP_FIM;
            OP_FIM:      n_op = OP_FZV;
            OP_FZV:      n_op = OP_KICK;
            OP_KICK: begin
                if (!i_sts.cmd) begin
                    n_op = OP_DRIFT;
                end else begin
                    n_op   = comp_op;
                    n_comp = more_comp ? r_comp + 2'd1 : r_comp;
                end
            end
            OP_DRIFT: begin
                n_op   = comp_op;
                n_comp = more_comp ? r_comp + 2'd1 : r_comp;
            end
            OP_ITEM_END: begin
                if (!i_sts.last) begin
                    n_op = OP_EMIT;
                end else begin
                    n_op = i_sts.q_valid ? OP_TK : after_z;
                end
            end
            OP_TK:       n_op = OP_TW;
            OP_TW:       n_op = OP_NUM;
            OP_NUM:      n_op = OP_ZDIV;
            OP_ZDIV:     n_op = after_z;
            OP_DEN:      n_op = OP_LDIV;
            OP_LDIV:     n_op = OP_CLOSE;
            OP_CLOSE:    n_op = OP_EMIT;
            default:     n_op = OP_EMIT;
        endcase
    end

    // state and registered command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_KSQ;
            r_comp  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_op    <= OP_KSQ;
                        r_comp  <= '0;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (i_sts.done) begin
                        if (r_op == OP_EMIT) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_op    <= n_op;
                            r_comp  <= n_comp;
                            r_state <= S_START;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cmd.start = (r_state == S_START);
    assign o_cmd.op    = r_op;
    assign o_cmd.comp  = r_comp;
    assign o_in_ready  = (r_state == S_IDLE);

    `NHV_ASSERT(a_done_in_wait, i_sts.done |-> r_state == S_WAIT, "done outside wait")
    `NHV_ASSERT_NEXT(a_accept_start, i_accept, r_state == S_START, "accept did not start")
endmodule

[sv/nhv_datapath.sv]
`include "nose_hoover_verlet_step_assert.svh"

module nhv_datapath #(
    parameter int MAX_PARTICLES = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  nhv_pkg::t_dp_cmd i_cmd,
    output nhv_pkg::t_dp_sts o_sts,
    input  logic             i_load,
    input  nhv_pkg::t_item   i_item,
    input  logic             i_cfg_wr_en,
    input  logic [2:0]       i_cfg_index,
    input  logic [31:0]      i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output nhv_pkg::t_result o_res
);
    import nhv_pkg::*;

    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);

    // configuration
    logic [31:0]        r_ts;
    logic signed [31:0] r_tq;
    logic signed [31:0] r_tt;
    logic [31:0]        r_kb;
    logic [1:0]         r_dims;
    logic [15:0]        r_wait;

    // thermostat state
    logic signed [31:0] r_zeta;
    logic [47:0]        r_ksum;
    logic [CNT_W-1:0]   r_count;
    logic [15:0]        r_step;
    logic signed [31:0] r_lt;
    logic signed [31:0] r_lq;
    logic               r_lflag;

    // particle work registers
    t_item              r_item;
    logic [31:0]        r_im;
    logic [47:0]        r_ke;
    logic [2:0][31:0]   r_nvel;
    logic [2:0][31:0]   r_npos;
    logic signed [63:0] r_t1;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_deriv;

    // multiplier and sequencing
    logic [63:0]        r_pp_lo;
    logic [62:0]        r_pp_hi;
    logic signed [63:0] r_prod;
    logic               r_run;
    logic [1:0]         r_phase;
    logic               r_out_valid;
    t_result            r_res;

    logic [31:0]        kb_use;
    logic [1:0]         d_use;
    logic signed [31:0] temp_use;
    logic signed [31:0] q_use;
    logic               q_valid;
    logic               unset;
    logic               waiting;
    logic [CNT_W+1:0]   dn;
    logic [CNT_W+1:0]   dn_m1;
    logic [1:0]         k;
    logic signed [63:0] a_val;
    logic signed [32:0] b_val;
    logic               sat_en;
    logic [62:0]        a_mag;
    logic [31:0]        b_mag;
    logic               p_neg;
    logic [94:0]        full;
    logic [63:0]        mag;
    logic               is_mul;
    logic               is_div;
    logic               div_start;
    logic               div_done;
    logic [63:0]        quo;
    logic [63:0]        dvd;
    logic [63:0]        dvs;
    logic               done;
    logic [64:0]        ke_sum;
    logic [48:0]        ks_sum;
    logic signed [63:0] zq;
    logic signed [63:0] den3;

    // values in use
    always_comb begin
        kb_use  = (r_kb == 32'd0) ? 32'd1 : r_kb;
        if (r_dims == 2'd0) begin
            d_use = 2'd1;
        end else if (32'(r_dims) > MAX_DIMS) begin
            d_use = 2'(MAX_DIMS);
        end else begin
            d_use = r_dims;
        end
        if (r_tt >= 32'sd0) begin
            temp_use = r_tt;
        end else if (r_lflag) begin
            temp_use = r_lt;
        end else begin
            temp_use = r_tt;
        end
        if (r_tq > 32'sd0) begin
            q_use = r_tq;
        end else if (r_lflag && r_lq > 32'sd0) begin
            q_use = r_lq;
        end else begin
            q_use = 32'sd0;
        end
        q_valid = (r_tq > 32'sd0) || (r_lflag && r_lq > 32'sd0);
        unset   = (r_tt < 32'sd0) && !r_lflag;
        waiting = r_step < r_wait;
        dn      = (d_use[1] ? {1'b0, r_count, 1'b0} : '0) + (d_use[0] ? {2'b0, r_count} : '0);
        dn_m1   = dn - 1'b1;
        k       = i_cmd.comp;
    end

    // multiplier operand selection
    always_comb begin
        a_val  = '0;
        b_val  = '0;
        sat_en = 1'b0;
        is_mul = 1'b0;
        is_div = 1'b0;
        case (i_cmd.op)
            OP_KSQ: begin
                a_val  = sx64(r_item.vel[k]);
                b_val  = {r_item.vel[k][31], r_item.vel[k]};
                is_mul = 1'b1;
            end
            OP_FIM: begin
                a_val  = sx64(r_item.frc[k]);
                b_val  = {1'b0, r_im};
                is_mul = 1'b1;
            end
            OP_FZV: begin
                a_val  = sx64(r_item.vel[k]);
                b_val  = {r_zeta[31], r_zeta};
                is_mul = 1'b1;
            end
            OP_KICK: begin
                a_val  = sx64(r_deriv);
                b_val  = {1'b0, r_ts};
                is_mul = 1'b1;
            end
            OP_DRIFT: begin
                a_val  = sx64(r_nvel[k]);
                b_val  = {1'b0, r_ts};
                is_mul = 1'b1;
            end
            OP_TK: begin
                a_val  = sx64(temp_use);
                b_val  = {1'b0, kb_use};
                sat_en = 1'b1;
                is_mul = 1'b1;
            end
            OP_TW: begin
                a_val  = r_t1;
                b_val  = 33'(dn_m1);
                sat_en = 1'b1;
                is_mul = 1'b1;
            end
            OP_NUM: begin
                a_val  = r_acc;
                b_val  = {1'b0, r_ts};
                sat_en = 1'b1;
                is_mul = 1'b1;
            end
            OP_DEN: begin
                a_val  = 64'(r_count);
                b_val  = {1'b0, kb_use};
                is_mul = 1'b1;
            end
            OP_KDIV, OP_ZDIV, OP_LDIV: is_div = 1'b1;
            default: ;
        endcase
        a_mag = a_val[63] ? 63'(-a_val) : a_val[62:0];
        b_mag = b_val[32] ? 32'(-b_val) : b_val[31:0];
        p_neg = a_val[63] ^ b_val[32];
        full  = {r_pp_hi, 32'b0} + {31'b0, r_pp_lo};
        if (sat_en && full > {31'b0, SAT_WIDE}) begin
            mag = SAT_WIDE;
        end else begin
            mag = full[63:0];
        end
    end

    // divider operand selection
    always_comb begin
        case (i_cmd.op)
            OP_ZDIV: begin
                dvd = r_acc[63] ? ~r_acc : r_acc;
                dvs = {30'b0, q_use, 2'b0};
            end
            OP_LDIV: begin
                dvd = {r_ksum, 16'b0};
                dvs = r_acc;
            end
            default: begin
                dvd = r_acc;
                dvs = {32'b0, r_im};
            end
        endcase
    end

    assign div_start = r_run && is_div && (r_phase == 2'd0);

    nhv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    // completion of the running operation
    always_comb begin
        if (!r_run) begin
            done = 1'b0;
        end else if (is_mul) begin
            done = (r_phase == 2'd3);
        end else if (is_div) begin
            done = (r_phase == 2'd1) && div_done;
        end else if (i_cmd.op == OP_EMIT) begin
            done = !r_out_valid || i_out_ready;
        end else begin
            done = 1'b1;
        end
        ke_sum = {17'b0, r_ke} + {1'b0, quo};
        ks_sum = {1'b0, r_ksum} + {1'b0, r_ke};
        zq     = r_acc[63] ? ~quo : quo;
        den3   = (d_use[1] ? (r_prod <<< 1) : 64'sd0) + (d_use[0] ? r_prod : 64'sd0);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts   <= 32'd66;
            r_tq   <= 32'sd6553600;
            r_tt   <= -32'sd65536;
            r_kb   <= 32'd65536;
            r_dims <= 2'd2;
            r_wait <= 16'd2500;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_TIME_STEP:   r_ts   <= i_cfg_data;
                CFG_THERMO_MASS: r_tq   <= i_cfg_data;
                CFG_TARGET_TEMP: r_tt   <= i_cfg_data;
                CFG_BOLTZMANN:   r_kb   <= i_cfg_data;
                CFG_DIMENSIONS:  r_dims <= i_cfg_data[1:0];
                CFG_WAIT_STEPS:  r_wait <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // multiplier partial products, two passes then a combine
    always_ff @(posedge i_clk) begin
        if (r_run && is_mul) begin
            case (r_phase)
                2'd0:    r_pp_lo <= 64'(a_mag[31:0]) * 64'(b_mag);
                2'd1:    r_pp_hi <= 63'(a_mag[62:32]) * 63'(b_mag);
                2'd2:    r_prod  <= p_neg ? -$signed(mag) : $signed(mag);
                default: ;
            endcase
        end
    end

    // sequencing of one operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_phase <= '0;
        end else if (i_cmd.start) begin
            r_run   <= 1'b1;
            r_phase <= '0;
        end else if (done) begin
            r_run <= 1'b0;
        end else if (r_run && (is_mul || (is_div && r_phase == 2'd0))) begin
            r_phase <= r_phase + 2'd1;
        end
    end

    // particle load and per-item results
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
            r_im   <= (i_item.inverse_mass == 32'd0) ? 32'd1 : i_item.inverse_mass;
            r_ke   <= '0;
            r_nvel <= i_item.vel;
            r_npos <= i_item.pos;
        end else if (done) begin
            case (i_cmd.op)
                OP_KSQ:   r_acc   <= r_prod;
                OP_KDIV:  r_ke    <= (ke_sum > {17'b0, KSUM_MAX}) ? KSUM_MAX : ke_sum[47:0];
                OP_FIM:   r_t1    <= r_prod >>> FRAC_BITS;
                OP_FZV:   r_deriv <= sat32(r_t1 - (r_prod >>> FRAC_BITS));
                OP_KICK:  r_nvel[k] <= sat32(sx64(r_item.vel[k]) + (r_prod >>> (FRAC_BITS + 1)));
                OP_DRIFT: r_npos[k] <= sat32(sx64(r_item.pos[k]) + (r_prod >>> FRAC_BITS));
                OP_TK:    r_t1    <= r_prod >>> FRAC_BITS;
                OP_TW:    r_acc   <= sat_wide($signed({16'b0, r_ksum}) - r_prod);
                OP_NUM:   r_acc   <= r_prod;
                OP_DEN:   r_acc   <= den3;
                default: ;
            endcase
        end
    end

    // thermostat state and pass end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zeta  <= '0;
            r_ksum  <= '0;
            r_count <= '0;
            r_step  <= '0;
            r_lt    <= '0;
            r_lq    <= '0;
            r_lflag <= 1'b0;
        end else if (done) begin
            case (i_cmd.op)
                OP_ITEM_END: begin
                    r_ksum <= (ks_sum > {1'b0, KSUM_MAX}) ? KSUM_MAX : ks_sum[47:0];
                    if (r_count < CNT_MAX) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                OP_ZDIV: r_zeta <= sat32(sx64(r_zeta) + zq);
                OP_LDIV: begin
                    r_lt <= (quo[63:31] != '0) ? I32_MAX : {1'b0, quo[30:0]};
                    if (r_tq <= 32'sd0) begin
                        r_lq <= (r_ksum[47:31] != '0) ? I32_MAX : {1'b0, r_ksum[30:0]};
                    end
                    r_lflag <= 1'b1;
                end
                OP_CLOSE: begin
                    if (unset && waiting) begin
                        r_zeta <= '0;
                    end
                    if (r_item.command && r_step != 16'hFFFF) begin
                        r_step <= r_step + 16'd1;
                    end
                    r_ksum  <= '0;
                    r_count <= '0;
                end
                default: ;
            endcase
        end
    end

    // output register, parts the result from the next particle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done && i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && i_cmd.op == OP_EMIT) begin
            r_res.nvel        <= r_nvel;
            r_res.npos        <= r_npos;
            r_res.friction    <= r_zeta;
            r_res.temperature <= temp_use;
            r_res.pass_done   <= r_item.last_particle;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_res         = r_res;
    assign o_sts.done    = done;
    assign o_sts.cmd     = r_item.command;
    assign o_sts.last    = r_item.last_particle;
    assign o_sts.dims    = d_use;
    assign o_sts.q_valid = q_valid;
    assign o_sts.learn_now = unset && !waiting && !r_item.command;

    `NHV_ASSERT(a_no_restart, !(i_cmd.start && r_run), "operation started while busy")
    `NHV_ASSERT(a_count_cap, r_count <= CNT_MAX, "particle count above its limit")
endmodule

[sv/nose_hoover_verlet_step.sv]
// Nose-Hoover velocity Verlet step over a stream of particles in Q16.16. Command 0
// applies the first half kick and the drift, command 1 the second half kick; the
// word marked last closes the pass, updates the thermostat friction when Q is valid
// and may learn the temperature and Q. One particle at a time is worked: nearly
// all the work of each spatial component in use lies in the shared
// one-bit-per-cycle divider (64 steps for the kinetic term) and the two-pass 32x32
// multiplier. A closing word adds further operations, and more when it also learns
// the temperature. A finished result waits in an output register while the next
// particle is accepted.
module nose_hoover_verlet_step #(
    parameter int MAX_PARTICLES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nhv_in_if.sink      i_in,
    nhv_out_if.source   o_out,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import nhv_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    t_item   item;
    t_result res;
    logic    in_ready;
    logic    accept;
    logic    out_valid;

    // input word packing
    assign item.command       = i_in.command;
    assign item.pos[0]        = i_in.pos_a;
    assign item.pos[1]        = i_in.pos_b;
    assign item.pos[2]        = i_in.pos_c;
    assign item.vel[0]        = i_in.vel_a;
    assign item.vel[1]        = i_in.vel_b;
    assign item.vel[2]        = i_in.vel_c;
    assign item.frc[0]        = i_in.force_a;
    assign item.frc[1]        = i_in.force_b;
    assign item.frc[2]        = i_in.force_c;
    assign item.inverse_mass  = i_in.inverse_mass;
    assign item.last_particle = i_in.last_particle;

    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    nhv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_in_ready (in_ready)
    );

    nhv_datapath #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_load      (accept),
        .i_item      (item),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_res       (res)
    );

    // result word unpacking
    assign o_out.valid           = out_valid;
    assign o_out.new_vel_a       = res.nvel[0];
    assign o_out.new_vel_b       = res.nvel[1];
    assign o_out.new_vel_c       = res.nvel[2];
    assign o_out.new_pos_a       = res.npos[0];
    assign o_out.new_pos_b       = res.npos[1];
    assign o_out.new_pos_c       = res.npos[2];
    assign o_out.friction_out    = res.friction;
    assign o_out.temperature_out = res.temperature;
    assign o_out.pass_done       = res.pass_done;
endmodule
